@@ sv/sui_pkg.sv @@
// shared types and constants for the sorted unique index set
`timescale 1ns / 1ps
`default_nettype none

package sui_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_LIMIT  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [FIELD_W-1:0] index;
    logic               no_limit;
  } item_t;

  typedef struct packed {
    logic             present;
    logic [CNT_W-1:0] entry_count;
    logic [1:0]       status;
  } result_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                  capture;
    logic                  ins;
    logic                  del;
    logic [INDEX_BITS-1:0] idx;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sorted_unique_index_set.sv @@
// top level of the sorted unique index set: control, counters and cell chain
//
//  channel   direction  handshake          payload
//  command   in         start / busy       in_i  (item_t)
//  result    out        done_o strobe      res_o (result_t)
//
// each command runs a compare in every cell, then a shift and update
// busy is high in the compare cycle only, so a new command can be taken while
// the previous one updates; the result strobe follows in the cycle after the update
// reset clears the count and the limit; cell contents need no reset
// the receiver cannot stall, every result is shown for one cycle
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_index_set import sui_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   in_i,
  output logic    done_o,
  output result_t res_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [2:0]            cmd_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic                  nolim_q;
  logic                  lim_hit_q;
  logic [CNT_W-1:0]      total_q, total_d;
  logic [INDEX_BITS-1:0] limit_q, limit_d;
  logic                  lim_act_q, lim_act_d;
  result_t               res_q, res_d;
  logic                  done_q;

  logic accept, upd;
  logic present, full;
  logic [CNT_W-1:0] pos;
  status_e status;
  cell_ctrl_t ctrl;

  logic [INDEX_BITS-1:0] entry   [CAPACITY];
  logic [CAPACITY-1:0]   below, eq, valid;
  logic [CAPACITY:0]     below_ext;

  assign accept = start && !busy;
  assign busy   = (state_q == S_CMP);
  assign upd    = (state_q == S_UPD);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD:   state_d = start ? S_CMP : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      lim_act_q <= 1'b0;
      limit_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      lim_act_q <= lim_act_d;
      limit_q   <= limit_d;
      done_q    <= upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_i.cmd;
      idx_q   <= in_i.index[INDEX_BITS-1:0];
      nolim_q <= in_i.no_limit;
    end
    if (busy) begin
      lim_hit_q <= lim_act_q && (idx_q >= limit_q);
    end
    if (upd) begin
      res_q <= res_d;
    end
  end

  // chain of cells
  assign below_ext = {1'b0, below};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [INDEX_BITS-1:0] left_e, right_e;
    logic                  left_b;
    assign valid[i] = (total_q > CNT_W'(i));
    if (i == 0) begin : g_first
      assign left_e = idx_q;
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_e = entry[i-1];
      assign left_b = below[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entry[i];
    end else begin : g_inner
      assign right_e = entry[i+1];
    end
    sui_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .valid_i       (valid[i]),
      .left_entry_i  (left_e),
      .left_below_i  (left_b),
      .right_entry_i (right_e),
      .entry_o       (entry[i]),
      .below_o       (below[i]),
      .eq_o          (eq[i])
    );
  end

  // below flags form a thermometer, so the insertion point is its edge
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (below_ext[i] && !below_ext[i+1]) begin
        pos = pos | CNT_W'(i + 1);
      end
    end
  end

  assign present = |eq;
  assign full    = (total_q == CNT_W'(CAPACITY));

  always_comb begin
    ctrl.capture = busy;
    ctrl.idx     = idx_q;
    ctrl.ins     = 1'b0;
    ctrl.del     = 1'b0;
    total_d      = total_q;
    limit_d      = limit_q;
    lim_act_d    = lim_act_q;
    status       = ST_OK;
    if (upd) begin
      case (cmd_q)
        CMD_ADD: begin
          if (lim_hit_q) begin
            status = ST_RANGE;
          end else if (!present) begin
            if (full) begin
              status = ST_FULL;
            end else begin
              ctrl.ins = 1'b1;
              total_d  = total_q + 1'b1;
            end
          end
        end
        CMD_REMOVE: begin
          if (present) begin
            ctrl.del = 1'b1;
            total_d  = total_q - 1'b1;
          end
        end
        CMD_CLEAR: total_d = '0;
        CMD_LIMIT: begin
          if (nolim_q) begin
            lim_act_d = 1'b0;
          end else begin
            lim_act_d = 1'b1;
            limit_d   = idx_q;
            total_d   = pos;
          end
        end
        default: ;
      endcase
    end
    res_d.present     = present;
    res_d.entry_count = total_d;
    res_d.status      = status;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

@@ sv/sui_cell.sv @@
// one cell of the sorted chain: holds one entry, compares and shifts
`timescale 1ns / 1ps
`default_nettype none

module sui_cell import sui_pkg::*; (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic                  valid_i,
  input  logic [INDEX_BITS-1:0] left_entry_i,
  input  logic                  left_below_i,
  input  logic [INDEX_BITS-1:0] right_entry_i,
  output logic [INDEX_BITS-1:0] entry_o,
  output logic                  below_o,
  output logic                  eq_o
);

  logic [INDEX_BITS-1:0] entry_q, entry_d;
  logic                  below_q, eq_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      // left neighbor not below the index: insertion point is left of us
      if (!left_below_i) begin
        entry_d = left_entry_i;
      end else if (!below_q) begin
        entry_d = ctrl_i.idx;
      end
    end
    if (ctrl_i.del && !below_q) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.capture) begin
      below_q <= valid_i && (entry_q < ctrl_i.idx);
      eq_q    <= valid_i && (entry_q == ctrl_i.idx);
    end
  end

  assign entry_o = entry_q;
  assign below_o = below_q;
  assign eq_o    = eq_q;

endmodule

`default_nettype wire

@@ sv/sui_checker.sv @@
// port-level checks for the sorted unique index set, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sui_checker import sui_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input result_t res_o
);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_busy_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // compare cycle, update cycle, then the result beat
  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##2 done_o)
    else $error("result beat missing");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_FULL) |-> res_o.entry_count == CNT_W'(CAPACITY))
    else $error("full status with list not full");

endmodule

bind sorted_unique_index_set sui_checker u_sui_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire

@@ tb/sv/tb_sorted_unique_index_set.sv @@
// testbench for the sorted unique index set: directed table, then random commands
`timescale 1ns / 1ps
`default_nettype none

module tb_sorted_unique_index_set;
  import sui_pkg::*;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   in_i;
  logic    done_o;
  result_t res_o;

  // predictor state: the ascending member list and the limit
  logic [INDEX_BITS-1:0] members[$];
  logic                  limit_on;
  logic [INDEX_BITS-1:0] limit_val;

  result_t               pending_results[$];
  dir_row_t              dir_tab[$];
  int                    fail_cnt;
  int                    idle_pct;
  logic [INDEX_BITS-1:0] pool_base;
  int                    drain_cycles;

  sorted_unique_index_set uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic result_t predict_set_cmd(item_t it);
    result_t               r;
    int                    pos;
    logic                  hit;
    logic [INDEX_BITS-1:0] v;
    v   = it.index[INDEX_BITS-1:0];
    pos = 0;
    while (pos < members.size() && members[pos] < v) pos++;
    hit      = (pos < members.size()) && (members[pos] == v);
    r.status = ST_OK;
    case (it.cmd)
      CMD_ADD: begin
        if (limit_on && v >= limit_val) begin
          r.status = ST_RANGE;
        end else if (!hit) begin
          if (members.size() >= CAPACITY) r.status = ST_FULL;
          else members.insert(pos, v);
        end
      end
      CMD_REMOVE: begin
        if (hit) members.delete(pos);
      end
      CMD_CLEAR: begin
        members.delete();
      end
      CMD_LIMIT: begin
        if (it.no_limit) begin
          limit_on = 1'b0;
        end else begin
          limit_val = v;
          limit_on  = 1'b1;
          // entries at or above the new limit are discarded
          while (members.size() > pos) void'(members.pop_back());
        end
      end
      default: ;
    endcase
    r.present     = hit;
    r.entry_count = CNT_W'(members.size());
    return r;
  endfunction

  function automatic dir_row_t row(logic [2:0] cmd, logic [FIELD_W-1:0] idx, logic nl,
                                   bit typed, logic p, int cnt, logic [1:0] st);
    dir_row_t d;
    d.it.cmd           = cmd;
    d.it.index         = idx;
    d.it.no_limit      = nl;
    d.typed            = typed;
    d.want.present     = p;
    d.want.entry_count = CNT_W'(cnt);
    d.want.status      = st;
    return d;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_index();
    if ($urandom_range(99) < 85) return FIELD_W'(pool_base + $urandom_range(95));
    return FIELD_W'($urandom);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    r;
    r           = $urandom_range(999);
    it.index    = pick_index();
    it.no_limit = 1'($urandom_range(1));
    if (r < 600)      it.cmd = CMD_ADD;
    else if (r < 740) it.cmd = CMD_REMOVE;
    else if (r < 860) it.cmd = CMD_QUERY;
    else if (r < 920) it.cmd = CMD_LIMIT;
    else if (r < 925) it.cmd = CMD_CLEAR;
    else if (r < 955) it.cmd = 3'($urandom_range(5, 7));
    else              it.cmd = CMD_ADD;
    return it;
  endfunction

  // entered and left at a falling edge; start stays high between back to back beats
  task automatic send(input item_t it, input bit typed, input result_t want);
    result_t r;
    int      gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      in_i  <= rand_item();
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    in_i  <= it;
    do @(posedge clk_i); while (busy);
    r = predict_set_cmd(it);
    pending_results.push_back(typed ? want : r);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: present %0d entry_count %0d status %0d",
               res_o.present, res_o.entry_count, res_o.status);
        fail_cnt++;
      end else begin
        if (res_o.present !== pending_results[0].present) begin
          $error("present: expected %0d, got %0d", pending_results[0].present,
                 res_o.present);
          fail_cnt++;
        end
        if (res_o.entry_count !== pending_results[0].entry_count) begin
          $error("entry_count: expected %0d, got %0d", pending_results[0].entry_count,
                 res_o.entry_count);
          fail_cnt++;
        end
        if (res_o.status !== pending_results[0].status) begin
          $error("status: expected %0d, got %0d", pending_results[0].status,
                 res_o.status);
          fail_cnt++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    result_t none;
    none      = '0;
    fail_cnt  = 0;
    idle_pct  = 0;
    limit_on  = 1'b0;
    limit_val = '0;
    pool_base = '0;
    rst_ni    = 1'b0;
    start     = 1'b0;
    in_i      = '0;

    dir_tab.push_back(row(CMD_QUERY,  16'h0000, 1'b0, 1, 1'b0, 0, ST_OK));
    dir_tab.push_back(row(CMD_ADD,    16'h0000, 1'b0, 1, 1'b0, 1, ST_OK));
    dir_tab.push_back(row(CMD_ADD,    16'hFFFF, 1'b0, 1, 1'b0, 2, ST_OK));
    dir_tab.push_back(row(CMD_ADD,    16'h0000, 1'b0, 1, 1'b1, 2, ST_OK));
    dir_tab.push_back(row(CMD_QUERY,  16'hFFFF, 1'b0, 1, 1'b1, 2, ST_OK));
    dir_tab.push_back(row(CMD_REMOVE, 16'h1234, 1'b0, 1, 1'b0, 2, ST_OK));
    dir_tab.push_back(row(CMD_REMOVE, 16'h0000, 1'b0, 1, 1'b1, 1, ST_OK));
    dir_tab.push_back(row(CMD_LIMIT,  16'h8000, 1'b0, 1, 1'b0, 0, ST_OK));
    dir_tab.push_back(row(CMD_ADD,    16'h8000, 1'b0, 1, 1'b0, 0, ST_RANGE));
    dir_tab.push_back(row(CMD_ADD,    16'h7FFF, 1'b0, 1, 1'b0, 1, ST_OK));
    dir_tab.push_back(row(CMD_ADD,    16'hFFFF, 1'b0, 1, 1'b0, 1, ST_RANGE));
    dir_tab.push_back(row(CMD_LIMIT,  16'h0000, 1'b1, 1, 1'b0, 1, ST_OK));
    dir_tab.push_back(row(CMD_ADD,    16'hFFFF, 1'b0, 1, 1'b0, 2, ST_OK));
    dir_tab.push_back(row(3'd5,       16'h7FFF, 1'b0, 0, 1'b0, 0, ST_OK));
    dir_tab.push_back(row(3'd6,       16'hFFFF, 1'b0, 0, 1'b0, 0, ST_OK));
    dir_tab.push_back(row(3'd7,       16'hAAAA, 1'b1, 0, 1'b0, 0, ST_OK));
    dir_tab.push_back(row(CMD_CLEAR,  16'h7FFF, 1'b0, 1, 1'b1, 0, ST_OK));
    dir_tab.push_back(row(CMD_ADD,    16'h5555, 1'b0, 0, 1'b0, 0, ST_OK));
    dir_tab.push_back(row(CMD_ADD,    16'h2AAA, 1'b1, 0, 1'b0, 0, ST_OK));
    // a limit of zero empties the list
    dir_tab.push_back(row(CMD_LIMIT,  16'h0000, 1'b0, 1, 1'b0, 0, ST_OK));
    dir_tab.push_back(row(CMD_ADD,    16'h0000, 1'b0, 1, 1'b0, 0, ST_RANGE));
    dir_tab.push_back(row(CMD_LIMIT,  16'hFFFF, 1'b1, 0, 1'b0, 0, ST_OK));
    dir_tab.push_back(row(CMD_ADD,    16'h0001, 1'b0, 0, 1'b0, 0, ST_OK));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

    // no idling, sender idle 72 of 100, no idling, sender idle 15 of 100
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       idle_pct = 72;
        3:       idle_pct = 15;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < 320; n++) begin
        // move the working index window now and then, sometimes to the top of the range
        if (n % 160 == 0) begin
          pool_base = ($urandom_range(3) == 0) ? FIELD_W'(16'hFFFF - 95)
                                               : FIELD_W'($urandom_range(16'hFFFF - 95));
        end
        send(rand_item(), 1'b0, none);
      end
    end
    start <= 1'b0;

    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (pending_results.size() != 0) begin
      $display("Verification failed");
      $finish;
    end else begin
      repeat (10) @(posedge clk_i);
      if (fail_cnt == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
      $finish;
    end
  end

endmodule

`default_nettype wire
